// ===== hw/rtl/dsf_pkg.sv =====
// shared types and constants for the damped spring force block
`timescale 1ns / 1ps
`default_nettype none
package dsf_pkg;

   localparam logic [1:0] CSR_STIFFNESS   = 2'd0;
   localparam logic [1:0] CSR_DAMPING     = 2'd1;
   localparam logic [1:0] CSR_REST_LENGTH = 2'd2;

   typedef struct packed {
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_a_z;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] pos_b_z;
      logic signed [31:0] vel_a_x;
      logic signed [31:0] vel_a_y;
      logic signed [31:0] vel_a_z;
      logic signed [31:0] vel_b_x;
      logic signed [31:0] vel_b_y;
      logic signed [31:0] vel_b_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] spring_x;
      logic signed [31:0] spring_y;
      logic signed [31:0] spring_z;
      logic signed [31:0] damper_x;
      logic signed [31:0] damper_y;
      logic signed [31:0] damper_z;
      logic [31:0]        spring_length;
      logic               zero_length;
   } rsp_type;

   // classified beat handed from front to back, sign and magnitude form
   typedef struct packed {
      logic [2:0]        dneg;
      logic [2:0][31:0]  dmag;
      logic [2:0]        dvneg;
      logic [2:0][31:0]  dvmag;
      logic [65:0]       sumsq;
      logic              zero;
   } item_type;

   typedef struct packed {
      logic [31:0] stiffness;
      logic [31:0] damping;
      logic [30:0] rest_length;
   } csr_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dsf_front.sv =====
// front end: takes a request beat, forms differences and the squared length
`timescale 1ns / 1ps
`default_nettype none
module dsf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dsf_pkg::req_type  req_payload,
   output logic              item_valid,
   output dsf_pkg::item_type item,
   input  logic              item_stall
);
   import dsf_pkg::*;

   logic        front_valid_ff;
   item_type    item_ff;
   item_type    item_in;
   logic [31:0] pa [3];
   logic [31:0] pb [3];
   logic [31:0] va [3];
   logic [31:0] vb [3];
   logic [32:0] d [3];
   logic [32:0] dv [3];
   logic [63:0] sq [3];

   assign req_stall  = front_valid_ff && item_stall;
   assign item_valid = front_valid_ff;
   assign item       = item_ff;

   always_comb begin
      pa[0] = req_payload.pos_a_x;  pa[1] = req_payload.pos_a_y;  pa[2] = req_payload.pos_a_z;
      pb[0] = req_payload.pos_b_x;  pb[1] = req_payload.pos_b_y;  pb[2] = req_payload.pos_b_z;
      va[0] = req_payload.vel_a_x;  va[1] = req_payload.vel_a_y;  va[2] = req_payload.vel_a_z;
      vb[0] = req_payload.vel_b_x;  vb[1] = req_payload.vel_b_y;  vb[2] = req_payload.vel_b_z;
      item_in = '0;
      for (int i = 0; i < 3; i++) begin
         d[i]  = {pb[i][31], pb[i]} - {pa[i][31], pa[i]};
         dv[i] = {vb[i][31], vb[i]} - {va[i][31], va[i]};
         item_in.dneg[i]  = d[i][32];
         item_in.dmag[i]  = d[i][32] ? 32'(33'd0 - d[i]) : d[i][31:0];
         item_in.dvneg[i] = dv[i][32];
         item_in.dvmag[i] = dv[i][32] ? 32'(33'd0 - dv[i]) : dv[i][31:0];
         sq[i] = 64'(item_in.dmag[i]) * 64'(item_in.dmag[i]);
      end
      item_in.sumsq = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
      item_in.zero  = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         front_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/dsf_queue.sv =====
// short queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module dsf_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  dsf_pkg::item_type push_item,
   output logic              push_stall,
   output logic              pop_valid,
   output dsf_pkg::item_type pop_item,
   input  logic              pop_take
);
   import dsf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;
   logic            push, pop;

   assign push_stall = (cnt_ff == CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && pop_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/dsf_back.sv =====
// back end: pipelined square root, division and force products
`timescale 1ns / 1ps
`default_nettype none
module dsf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  dsf_pkg::item_type item,
   output logic              item_take,
   input  dsf_pkg::csr_type  cfg,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dsf_pkg::rsp_type  rsp_payload
);
   import dsf_pkg::*;

   localparam int SQ_STEPS  = 33;
   localparam int DIV_STEPS = 31;
   localparam int LAST      = SQ_STEPS + DIV_STEPS + 1;

   typedef struct packed {
      item_type          it;
      logic [35:0]       rem;
      logic [32:0]       root;
      logic [2:0][32:0]  r;
      logic [2:0][30:0]  q;
   } pipe_type;

   typedef struct packed {
      logic              zero;
      logic [32:0]       len;
      logic [2:0]        dneg;
      logic [2:0][30:0]  q;
      logic              sneg;
      logic [64:0]       ps;
      logic [2:0]        tneg;
      logic [2:0][62:0]  tp;
   } m1_type;

   typedef struct packed {
      logic              zero;
      logic [32:0]       len;
      logic [2:0]        dneg;
      logic [2:0][30:0]  q;
      logic              sneg;
      logic [2:0][63:0]  ps_lo;
      logic [2:0][62:0]  ps_hi;
      logic              dotneg;
      logic [63:0]       dotm;
   } m2_type;

   typedef struct packed {
      logic              zero;
      logic [32:0]       len;
      logic [2:0]        dneg;
      logic [2:0][30:0]  q;
      logic [2:0][31:0]  spr;
      logic              dnb;
      logic [63:0]       pd_lo;
      logic [63:0]       pd_hi;
   } m3_type;

   typedef struct packed {
      logic              zero;
      logic [32:0]       len;
      logic [2:0]        dneg;
      logic [2:0][30:0]  q;
      logic [2:0][31:0]  spr;
      logic              dnb;
      logic [95:0]       pd;
   } m4_type;

   typedef struct packed {
      logic              zero;
      logic [32:0]       len;
      logic [2:0]        dneg;
      logic [2:0][31:0]  spr;
      logic              dnb;
      logic [2:0][2:0][62:0] pc;
   } m5_type;

   typedef struct packed {
      logic              zero;
      logic [32:0]       len;
      logic [2:0][31:0]  spr;
      logic [2:0][31:0]  dmp;
   } m6_type;

   function automatic logic [31:0] sat_signed(input logic [50:0] m, input logic neg);
      logic [50:0] lim;
      logic [31:0] v;
      lim = neg ? 51'h0_8000_0000 : 51'h0_7FFF_FFFF;
      v   = (m > lim) ? lim[31:0] : m[31:0];
      return neg ? (32'd0 - v) : v;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return s[31:0];
   endfunction

   logic     adv;
   logic     pv_ff [LAST+1];
   pipe_type pipe_ff [LAST+1];
   pipe_type pipe_in [LAST];
   pipe_type pipe0_in;

   logic     m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff, m5_v_ff, m6_v_ff, rsp_v_ff;
   m1_type   m1_ff, m1_in;
   m2_type   m2_ff, m2_in;
   m3_type   m3_ff, m3_in;
   m4_type   m4_ff, m4_in;
   m5_type   m5_ff, m5_in;
   m6_type   m6_ff, m6_in;
   rsp_type  rsp_ff, rsp_in;

   // whole pipe moves unless a finished beat is held at the output
   assign adv         = !(rsp_v_ff && rsp_stall);
   assign item_take   = adv && item_valid;
   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      pipe0_in      = '0;
      pipe0_in.it   = item;
   end

   genvar k;
   generate
      for (k = 0; k < LAST; k++) begin : g_step
         if (k < SQ_STEPS) begin : g_sqrt
            // one result bit per stage, two radicand bits shifted in
            logic [35:0] remsh, trial;
            always_comb begin
               remsh = {pipe_ff[k].rem[33:0], pipe_ff[k].it.sumsq[65-2*k -: 2]};
               trial = {1'b0, pipe_ff[k].root, 2'b01};
               pipe_in[k] = pipe_ff[k];
               if (remsh >= trial) begin
                  pipe_in[k].rem  = remsh - trial;
                  pipe_in[k].root = {pipe_ff[k].root[31:0], 1'b1};
               end else begin
                  pipe_in[k].rem  = remsh;
                  pipe_in[k].root = {pipe_ff[k].root[31:0], 1'b0};
               end
            end
         end else if (k == SQ_STEPS) begin : g_div_init
            always_comb begin
               pipe_in[k] = pipe_ff[k];
               for (int i = 0; i < 3; i++) begin
                  pipe_in[k].r[i] = {2'b00, pipe_ff[k].it.dmag[i][31:1]};
                  pipe_in[k].q[i] = '0;
               end
            end
         end else begin : g_div
            // restoring division, one quotient bit per stage per lane
            logic [33:0] rsh [3];
            logic [33:0] dif [3];
            always_comb begin
               pipe_in[k] = pipe_ff[k];
               for (int i = 0; i < 3; i++) begin
                  if (k == SQ_STEPS + 1) begin
                     rsh[i] = {pipe_ff[k].r[i], pipe_ff[k].it.dmag[i][0]};
                  end else begin
                     rsh[i] = {pipe_ff[k].r[i], 1'b0};
                  end
                  dif[i] = rsh[i] - {1'b0, pipe_ff[k].root};
                  if (rsh[i] >= {1'b0, pipe_ff[k].root}) begin
                     pipe_in[k].r[i] = dif[i][32:0];
                     pipe_in[k].q[i] = {pipe_ff[k].q[i][29:0], 1'b1};
                  end else begin
                     pipe_in[k].r[i] = rsh[i][32:0];
                     pipe_in[k].q[i] = {pipe_ff[k].q[i][29:0], 1'b0};
                  end
               end
            end
         end
      end
   endgenerate

   // spring product and the dot product terms
   logic [33:0] ext;
   logic [32:0] ext_mag;
   logic [31:0] stiff_mag;
   always_comb begin
      ext       = {1'b0, pipe_ff[LAST].root} - {3'b000, cfg.rest_length};
      ext_mag   = ext[33] ? 33'(34'd0 - ext) : ext[32:0];
      stiff_mag = cfg.stiffness[31] ? (32'd0 - cfg.stiffness) : cfg.stiffness;
      m1_in.zero = pipe_ff[LAST].it.zero;
      m1_in.len  = pipe_ff[LAST].root;
      m1_in.dneg = pipe_ff[LAST].it.dneg;
      m1_in.q    = pipe_ff[LAST].q;
      m1_in.sneg = cfg.stiffness[31] ^ ext[33];
      m1_in.ps   = 65'(stiff_mag) * 65'(ext_mag);
      for (int i = 0; i < 3; i++) begin
         m1_in.tneg[i] = pipe_ff[LAST].it.dvneg[i] ^ pipe_ff[LAST].it.dneg[i];
         m1_in.tp[i]   = 63'(pipe_ff[LAST].it.dvmag[i]) * 63'(pipe_ff[LAST].q[i]);
      end
   end

   logic [63:0] dpos, dnegs;
   always_comb begin
      dpos  = '0;
      dnegs = '0;
      for (int i = 0; i < 3; i++) begin
         if (m1_ff.tneg[i]) begin
            dnegs = dnegs + 64'(m1_ff.tp[i]);
         end else begin
            dpos = dpos + 64'(m1_ff.tp[i]);
         end
      end
      m2_in.zero   = m1_ff.zero;
      m2_in.len    = m1_ff.len;
      m2_in.dneg   = m1_ff.dneg;
      m2_in.q      = m1_ff.q;
      m2_in.sneg   = m1_ff.sneg;
      m2_in.dotneg = dnegs > dpos;
      m2_in.dotm   = (dnegs > dpos) ? (dnegs - dpos) : (dpos - dnegs);
      for (int i = 0; i < 3; i++) begin
         m2_in.ps_lo[i] = 64'(m1_ff.ps[32:0]) * 64'(m1_ff.q[i]);
         m2_in.ps_hi[i] = 63'(m1_ff.ps[64:33]) * 63'(m1_ff.q[i]);
      end
   end

   logic [96:0] s_full [3];
   logic [31:0] damp_mag;
   always_comb begin
      damp_mag   = cfg.damping[31] ? (32'd0 - cfg.damping) : cfg.damping;
      m3_in.zero = m2_ff.zero;
      m3_in.len  = m2_ff.len;
      m3_in.dneg = m2_ff.dneg;
      m3_in.q    = m2_ff.q;
      m3_in.dnb  = cfg.damping[31] ^ m2_ff.dotneg;
      for (int i = 0; i < 3; i++) begin
         s_full[i]    = 97'(m2_ff.ps_lo[i]) + (97'(m2_ff.ps_hi[i]) << 33);
         m3_in.spr[i] = sat_signed(s_full[i][96:46], m2_ff.sneg ^ m2_ff.dneg[i]);
      end
      m3_in.pd_lo = 64'(damp_mag) * 64'(m2_ff.dotm[31:0]);
      m3_in.pd_hi = 64'(damp_mag) * 64'(m2_ff.dotm[63:32]);
   end

   always_comb begin
      m4_in.zero = m3_ff.zero;
      m4_in.len  = m3_ff.len;
      m4_in.dneg = m3_ff.dneg;
      m4_in.q    = m3_ff.q;
      m4_in.spr  = m3_ff.spr;
      m4_in.dnb  = m3_ff.dnb;
      m4_in.pd   = 96'(m3_ff.pd_lo) + (96'(m3_ff.pd_hi) << 32);
   end

   always_comb begin
      m5_in.zero = m4_ff.zero;
      m5_in.len  = m4_ff.len;
      m5_in.dneg = m4_ff.dneg;
      m5_in.spr  = m4_ff.spr;
      m5_in.dnb  = m4_ff.dnb;
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            m5_in.pc[i][c] = 63'(m4_ff.pd[32*c +: 32]) * 63'(m4_ff.q[i]);
         end
      end
   end

   logic [126:0] d_full [3];
   always_comb begin
      m6_in.zero = m5_ff.zero;
      m6_in.len  = m5_ff.len;
      m6_in.spr  = m5_ff.spr;
      for (int i = 0; i < 3; i++) begin
         d_full[i] = 127'(m5_ff.pc[i][0]) + (127'(m5_ff.pc[i][1]) << 32)
                   + (127'(m5_ff.pc[i][2]) << 64);
         m6_in.dmp[i] = sat_signed(d_full[i][126:76], m5_ff.dnb ^ m5_ff.dneg[i]);
      end
   end

   always_comb begin
      rsp_in = '0;
      if (m6_ff.zero) begin
         rsp_in.zero_length = 1'b1;
      end else begin
         rsp_in.force_x  = sat_add(m6_ff.spr[0], m6_ff.dmp[0]);
         rsp_in.force_y  = sat_add(m6_ff.spr[1], m6_ff.dmp[1]);
         rsp_in.force_z  = sat_add(m6_ff.spr[2], m6_ff.dmp[2]);
         rsp_in.spring_x = m6_ff.spr[0];
         rsp_in.spring_y = m6_ff.spr[1];
         rsp_in.spring_z = m6_ff.spr[2];
         rsp_in.damper_x = m6_ff.dmp[0];
         rsp_in.damper_y = m6_ff.dmp[1];
         rsp_in.damper_z = m6_ff.dmp[2];
         rsp_in.spring_length = m6_ff.len[32] ? 32'hFFFF_FFFF : m6_ff.len[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= LAST; j++) begin
            pv_ff[j] <= 1'b0;
         end
         m1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         m3_v_ff  <= 1'b0;
         m4_v_ff  <= 1'b0;
         m5_v_ff  <= 1'b0;
         m6_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         pv_ff[0] <= item_valid;
         for (int j = 0; j < LAST; j++) begin
            pv_ff[j+1] <= pv_ff[j];
         end
         m1_v_ff  <= pv_ff[LAST];
         m2_v_ff  <= m1_v_ff;
         m3_v_ff  <= m2_v_ff;
         m4_v_ff  <= m3_v_ff;
         m5_v_ff  <= m4_v_ff;
         m6_v_ff  <= m5_v_ff;
         rsp_v_ff <= m6_v_ff;
      end
      if (adv) begin
         pipe_ff[0] <= pipe0_in;
         for (int j = 0; j < LAST; j++) begin
            pipe_ff[j+1] <= pipe_in[j];
         end
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         m4_ff  <= m4_in;
         m5_ff  <= m5_in;
         m6_ff  <= m6_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/damped_spring_force.sv =====
// top level of the damped spring force block
//
// Request channel (req_valid, req_stall, req_payload) takes one beat with the
// positions and velocities of both spring ends; the response channel
// (rsp_valid, rsp_stall, rsp_payload) returns one beat per request with the
// spring, damper and total forces on end A, the length and a zero flag.
// A beat moves on a clock edge with valid high and stall low.
// Throughput is one beat per cycle while the receiver does not stall. A request
// passes one front stage, one queue slot, one pipeline input stage,
// 33 square root stages, one divider setup stage, 31 divider stages and
// 7 multiply and saturate stages.
// The csr port writes stiffness, damping and rest length; write it only while
// no beat is in flight.
// Synchronous reset empties front, queue and pipeline and clears the csr
// registers to zero. When the receiver stalls, the pipeline holds, the queue
// fills, and then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module damped_spring_force #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsf_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsf_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [31:0]      csr_wdata
);
   import dsf_pkg::*;

   csr_type  cfg_ff;
   item_type front_item, queue_item;
   logic     front_valid, queue_stall, queue_valid, queue_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STIFFNESS:   cfg_ff.stiffness   <= csr_wdata;
            CSR_DAMPING:     cfg_ff.damping     <= csr_wdata;
            CSR_REST_LENGTH: cfg_ff.rest_length <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   dsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .item_valid  (front_valid),
      .item        (front_item),
      .item_stall  (queue_stall)
   );

   dsf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_stall (queue_stall),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item),
      .pop_take   (queue_take)
   );

   dsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (queue_valid),
      .item        (queue_item),
      .item_take   (queue_take),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/dsf_checker.sv =====
// port-level checks for the damped spring force block
`timescale 1ns / 1ps
`default_nettype none
module dsf_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire dsf_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire dsf_pkg::rsp_type rsp_payload
);

   // a held response beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // a held request beat stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("request beat changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // zero flag and zero length go together
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.zero_length == (rsp_payload.spring_length == 32'd0)))
      else $error("zero flag disagrees with length");

   // coincident ends carry no force
   a_zero_force: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.zero_length |->
         rsp_payload.force_x == 0 && rsp_payload.force_y == 0 &&
         rsp_payload.force_z == 0 && rsp_payload.spring_x == 0 &&
         rsp_payload.damper_x == 0)
      else $error("force on zero length spring");

endmodule

bind damped_spring_force dsf_checker u_dsf_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_damped_spring_force.sv =====
// testbench for the damped spring force block: directed table, then random beats
`timescale 1ns / 1ps
`default_nettype none
module tb_damped_spring_force;
   import dsf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int RANDOM_BEATS   = 1950;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_STIFFNESS;
   logic [31:0] csr_wdata = '0;

   logic signed [31:0] stiff_q;
   logic signed [31:0] damp_q;
   logic [30:0]        rest_q;

   rsp_type expected_forces[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      hold_off = 1'b0;

   damped_spring_force dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [127:0] mag128(logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   // truncate toward zero by a shift, saturate to 32-bit signed
   function automatic logic signed [31:0] scale_sat(bit neg, logic [191:0] p, int sh);
      logic [191:0] q;
      q = p >> sh;
      if (!neg) return (q > 192'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
      if (q > 192'h80000000) return 32'sh80000000;
      return 32'(-$signed({1'b0, q[31:0]}));
   endfunction

   function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s > 33'sd2147483647) return 32'sh7FFFFFFF;
      if (s < -33'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   function automatic rsp_type spring_forces(req_type r);
      rsp_type o;
      logic signed [32:0] d[3], dv[3];
      logic signed [31:0] n[3], spr[3], dmp[3];
      logic [67:0] sumsq;
      logic [33:0] len, t;
      logic signed [127:0] dot, ext;
      logic [127:0] dotm, extm;
      logic [31:0] sm, dm;
      bit sn, dn;
      o = '0;
      d[0] = 33'(r.pos_b_x) - 33'(r.pos_a_x);
      d[1] = 33'(r.pos_b_y) - 33'(r.pos_a_y);
      d[2] = 33'(r.pos_b_z) - 33'(r.pos_a_z);
      dv[0] = 33'(r.vel_b_x) - 33'(r.vel_a_x);
      dv[1] = 33'(r.vel_b_y) - 33'(r.vel_a_y);
      dv[2] = 33'(r.vel_b_z) - 33'(r.vel_a_z);
      sumsq = '0;
      for (int i = 0; i < 3; i++) sumsq += 68'(mag128(128'(d[i]))) * 68'(mag128(128'(d[i])));
      if (sumsq == 0) begin
         o.zero_length = 1'b1;
         return o;
      end
      len = '0;
      for (int b = 33; b >= 0; b--) begin
         t = len | (34'd1 << b);
         if (68'(t) * 68'(t) <= sumsq) len = t;
      end
      dot = '0;
      for (int i = 0; i < 3; i++) begin
         n[i] = 32'((mag128(128'(d[i])) << 30) / 128'(len));
         if (d[i] < 0) n[i] = -n[i];
         dot += 128'(dv[i]) * 128'(n[i]);
      end
      ext = $signed(128'(len)) - $signed(128'(rest_q));
      extm = mag128(ext);
      dotm = mag128(dot);
      sm = 32'(mag128(128'(stiff_q)));
      dm = 32'(mag128(128'(damp_q)));
      for (int i = 0; i < 3; i++) begin
         sn = ((stiff_q < 0) != (ext < 0)) != (n[i] < 0);
         dn = ((damp_q < 0) != (dot < 0)) != (n[i] < 0);
         spr[i] = scale_sat(sn, 192'(sm) * 192'(extm) * 192'(mag128(128'(n[i]))), 46);
         dmp[i] = scale_sat(dn, 192'(dm) * 192'(dotm) * 192'(mag128(128'(n[i]))), 76);
      end
      o.spring_x = spr[0]; o.spring_y = spr[1]; o.spring_z = spr[2];
      o.damper_x = dmp[0]; o.damper_y = dmp[1]; o.damper_z = dmp[2];
      o.force_x = sat_add(spr[0], dmp[0]);
      o.force_y = sat_add(spr[1], dmp[1]);
      o.force_z = sat_add(spr[2], dmp[2]);
      o.spring_length = len > 34'hFFFFFFFF ? 32'hFFFFFFFF : len[31:0];
      return o;
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_STIFFNESS) stiff_q = val;
      else if (idx == CSR_DAMPING) damp_q = val;
      else if (idx == CSR_REST_LENGTH) rest_q = val[30:0];
      @(posedge clock);
   endtask

   // one beat; the table row gives an explicit expectation when has_exp is set
   task automatic send_beat(req_type r, bit has_exp, rsp_type e);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_forces.push_back(has_exp ? e : spring_forces(r));
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic req_type rand_beat();
      req_type r;
      int mode;
      mode = $urandom_range(0, 3);
      r.pos_a_x = rand_coord(mode); r.pos_a_y = rand_coord(mode);
      r.pos_a_z = rand_coord(mode); r.pos_b_x = rand_coord(mode);
      r.pos_b_y = rand_coord(mode); r.pos_b_z = rand_coord(mode);
      r.vel_a_x = rand_coord(mode); r.vel_a_y = rand_coord(mode);
      r.vel_a_z = rand_coord(mode); r.vel_b_x = rand_coord(mode);
      r.vel_b_y = rand_coord(mode); r.vel_b_z = rand_coord(mode);
      // coinciding ends now and then
      if ($urandom_range(0, 40) == 0) begin
         r.pos_b_x = r.pos_a_x; r.pos_b_y = r.pos_a_y; r.pos_b_z = r.pos_a_z;
      end
      return r;
   endfunction

   function automatic logic [31:0] rand_const();
      case ($urandom_range(0, 4))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom();
      endcase
   endfunction

   // receiver stall pattern, plus one long hold-off while the sender keeps going
   initial begin
      int phase;
      phase = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off) rsp_stall <= 1'b1;
         else if ((phase / 200) % 3 == 0) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 99) < 35);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_forces.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            rsp_type e;
            e = expected_forces.pop_front();
            if (e.force_x !== rsp_payload.force_x) begin
               $error("force_x exp %0d got %0d", e.force_x, rsp_payload.force_x); errors++; end
            if (e.force_y !== rsp_payload.force_y) begin
               $error("force_y exp %0d got %0d", e.force_y, rsp_payload.force_y); errors++; end
            if (e.force_z !== rsp_payload.force_z) begin
               $error("force_z exp %0d got %0d", e.force_z, rsp_payload.force_z); errors++; end
            if (e.spring_x !== rsp_payload.spring_x) begin
               $error("spring_x exp %0d got %0d", e.spring_x, rsp_payload.spring_x); errors++; end
            if (e.spring_y !== rsp_payload.spring_y) begin
               $error("spring_y exp %0d got %0d", e.spring_y, rsp_payload.spring_y); errors++; end
            if (e.spring_z !== rsp_payload.spring_z) begin
               $error("spring_z exp %0d got %0d", e.spring_z, rsp_payload.spring_z); errors++; end
            if (e.damper_x !== rsp_payload.damper_x) begin
               $error("damper_x exp %0d got %0d", e.damper_x, rsp_payload.damper_x); errors++; end
            if (e.damper_y !== rsp_payload.damper_y) begin
               $error("damper_y exp %0d got %0d", e.damper_y, rsp_payload.damper_y); errors++; end
            if (e.damper_z !== rsp_payload.damper_z) begin
               $error("damper_z exp %0d got %0d", e.damper_z, rsp_payload.damper_z); errors++; end
            if (e.spring_length !== rsp_payload.spring_length) begin
               $error("spring_length exp %0d got %0d", e.spring_length,
                      rsp_payload.spring_length); errors++; end
            if (e.zero_length !== rsp_payload.zero_length) begin
               $error("zero_length exp %0d got %0d", e.zero_length,
                      rsp_payload.zero_length); errors++; end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("damped_spring_force verification failed");
         $finish;
      end
   end

   typedef struct {
      req_type beat;
      bit      has_exp;
      rsp_type result;
   } stim_row_type;

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      rsp_type zero_rsp;
      req_type r;
      int burst;
      stiff_q = '0; damp_q = '0; rest_q = '0;
      zero_rsp = '0;
      zero_rsp.zero_length = 1'b1;

      // directed table
      row.has_exp = 1'b1; row.result = zero_rsp; row.beat = '0;
      rows.push_back(row);
      row.beat = '1; rows.push_back(row);
      row.beat = {{6{32'h7FFFFFFF}}, {6{32'h80000000}}}; rows.push_back(row);
      row.has_exp = 1'b0;
      row.beat = '0; row.beat.pos_b_x = 32'h0001_0000; row.beat.vel_b_x = 32'h0002_0000;
      rows.push_back(row);
      row.beat = '0; row.beat.pos_a_x = 32'h80000000; row.beat.pos_b_x = 32'h7FFFFFFF;
      row.beat.pos_a_y = 32'h80000000; row.beat.pos_b_y = 32'h7FFFFFFF;
      row.beat.pos_a_z = 32'h80000000; row.beat.pos_b_z = 32'h7FFFFFFF;
      row.beat.vel_a_x = 32'h7FFFFFFF; row.beat.vel_b_x = 32'h80000000;
      rows.push_back(row);
      row.beat = '0; row.beat.pos_b_y = 32'hFFFF_0000; row.beat.vel_a_y = 32'h7FFFFFFF;
      rows.push_back(row);
      row.beat = '0; row.beat.pos_b_z = 32'd1; rows.push_back(row);
      row.beat = {{3{32'h0003_0000}}, {3{32'hFFFD_0000}}, {6{32'h1234_5678}}};
      rows.push_back(row);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero constants first, then the extremes, then normal values
      for (int k = 0; k < 4; k++) begin
         if (k == 1) begin
            write_csr(CSR_STIFFNESS, 32'h7FFFFFFF);
            write_csr(CSR_DAMPING, 32'h80000000);
            write_csr(CSR_REST_LENGTH, 32'h7FFFFFFF);
         end else if (k == 2) begin
            write_csr(CSR_STIFFNESS, 32'h80000000);
            write_csr(CSR_DAMPING, 32'h7FFFFFFF);
            write_csr(CSR_REST_LENGTH, 32'h0);
         end else if (k == 3) begin
            write_csr(CSR_STIFFNESS, 32'h0002_8000);
            write_csr(CSR_DAMPING, 32'hFFFF_C000);
            write_csr(CSR_REST_LENGTH, 32'h0001_0000);
         end
         foreach (rows[j]) send_beat(rows[j].beat, rows[j].has_exp, rows[j].result);
         drain_and_settle();
      end

      // random phases, new constants between them
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_STIFFNESS, rand_const());
         write_csr(CSR_DAMPING, rand_const());
         write_csr(CSR_REST_LENGTH, p == 0 ? 32'h7FFFFFFF : rand_const());
         for (int n = 0; n < RANDOM_BEATS / 6; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RANDOM_BEATS / 6; b++, n++) begin
               r = rand_beat();
               // long receiver hold-off once, the sender keeps offering beats
               if (p == 1 && n == 10) fork
                  begin
                     hold_off = 1'b1;
                     repeat (300) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
               send_beat(r, 1'b0, zero_rsp);
            end
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         drain_and_settle();
      end

      if (errors == 0) $display("damped_spring_force verification clean");
      else $display("damped_spring_force verification failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_front.sv
hw/rtl/dsf_queue.sv
hw/rtl/dsf_back.sv
hw/rtl/damped_spring_force.sv
hw/rtl/dsf_checker.sv
tb/sv/tb_damped_spring_force.sv
